>>> hdl/register_machine_execute_macros.svh
// ----------------------------------------------------------------------------
// register machine execute: assertion macros
// shared helpers for concurrent checks clocked on aclk, held off in reset
// ----------------------------------------------------------------------------
`ifndef REGISTER_MACHINE_EXECUTE_MACROS_SVH
`define REGISTER_MACHINE_EXECUTE_MACROS_SVH

// same-cycle implication
`define RME_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// beat layouts, operation codes and error codes of the register machine
// execute block
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int IN_W  = 80;
    localparam int OUT_W = 56;

    localparam logic [3:0] K_ADD    = 4'd0;
    localparam logic [3:0] K_SUB    = 4'd1;
    localparam logic [3:0] K_MUL    = 4'd2;
    localparam logic [3:0] K_DIV    = 4'd3;
    localparam logic [3:0] K_DEC    = 4'd4;
    localparam logic [3:0] K_INC    = 4'd5;
    localparam logic [3:0] K_MOVIMM = 4'd6;
    localparam logic [3:0] K_COPY   = 4'd7;
    localparam logic [3:0] K_MARK   = 4'd8;
    localparam logic [3:0] K_JUMP   = 4'd9;
    localparam logic [3:0] K_JZ     = 4'd10;
    localparam logic [3:0] K_JPOINT = 4'd11;
    localparam logic [3:0] K_CMPLE  = 4'd12;
    localparam logic [3:0] K_READ   = 4'd13;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_DIVZ  = 2'd1;
    localparam logic [1:0] ERR_POINT = 2'd2;

    // first declared member sits in the highest bits
    typedef struct packed {
        logic [3:0]         pad;
        logic [15:0]        current_counter;
        logic [3:0]         point_index;
        logic [15:0]        jump_target;
        logic signed [31:0] immediate;
        logic [1:0]         src_reg;
        logic [1:0]         dest_reg;
        logic [3:0]         kind;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]         pad;
        logic [1:0]         error;
        logic               zero_flag;
        logic signed [31:0] reg_value;
        logic               branch_taken;
        logic [15:0]        next_counter;
    } out_beat_t;

endpackage

>>> hdl/register_machine_execute.sv
`include "register_machine_execute_macros.svh"
// ----------------------------------------------------------------------------
// register_machine_execute
// executes one decoded instruction against NUM_REGS registers, a zero flag
// and a list of saved jump points, one result beat per instruction beat
// ----------------------------------------------------------------------------
// One instruction is in flight at a time; s_tready is high only while the
// sequencer is idle. Most kinds pass from idle through execute to finish;
// multiply adds a shift-and-add loop, divide adds absolute-value steps, a
// restoring loop and a quotient negate. Both loops run one bit per cycle
// through the single shared DATA_WIDTH + 1 bit adder. The FSM returns to idle
// before the next beat is taken. A finished result is held in the output
// register, so the next instruction may start while it waits, but a second
// result waits until the first is taken. Registers read as zero after reset;
// a saved point is only valid once marked.
module register_machine_execute #(
    parameter int NUM_REGS   = 4,
    parameter int MAX_POINTS = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // kind, dest_reg, src_reg, immediate, jump_target, point_index,
    // current_counter, zero pad
    input  logic [rme_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // next_counter, branch_taken, reg_value, zero_flag, error, zero pad
    output logic [rme_pkg::OUT_W-1:0] m_tdata
);
    import rme_pkg::*;

    localparam int RIW  = $clog2(NUM_REGS);
    localparam int PAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int CW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int CNTW = $clog2(DATA_WIDTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ABSA = 3'd3;
    localparam logic [2:0] ST_ABSB = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_NEGQ = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    in_beat_t  s_beat;
    in_beat_t  in_reg;
    out_beat_t out_reg;

    logic [2:0]            state_reg;
    logic [RIW-1:0]        d_idx, s_idx, d_idx_reg;
    logic [DATA_WIDTH-1:0] rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   rf_vld_reg;
    logic [15:0]           pt_mem [MAX_POINTS];
    logic [15:0]           pt_rd_reg;
    logic [PCW-1:0]        pcount_reg;
    logic                  zero_reg;

    logic [DATA_WIDTH-1:0] a_raw_reg, b_raw_reg, a_op, b_op;
    logic                  a_vld_reg, b_vld_reg;
    logic [DATA_WIDTH-1:0] acc_reg, x_reg, y_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  neg_q_reg;
    logic                  wr_en_reg;
    logic [1:0]            err_reg;
    logic [15:0]           next_reg;
    logic                  taken_reg;
    logic                  m_tvalid_reg;

    logic [DATA_WIDTH:0]   add_x, add_y, add_sum, div_shift;
    logic                  add_sub;
    logic signed [CW-1:0]  imm_ext, a_ext, acc_ext;
    logic                  accept, load_out, pt_we, pt_room, pt_hit;

    assign s_beat   = in_beat_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(out_reg);

    // register index wraps modulo the register count
    always_comb begin
        if (32'(s_beat.dest_reg) >= NUM_REGS) begin
            d_idx = RIW'(32'(s_beat.dest_reg) - NUM_REGS);
        end else begin
            d_idx = RIW'(s_beat.dest_reg);
        end
        if (32'(s_beat.src_reg) >= NUM_REGS) begin
            s_idx = RIW'(32'(s_beat.src_reg) - NUM_REGS);
        end else begin
            s_idx = RIW'(s_beat.src_reg);
        end
    end

    assign a_op    = a_vld_reg ? a_raw_reg : '0;
    assign b_op    = b_vld_reg ? b_raw_reg : '0;
    assign imm_ext = CW'(in_reg.immediate);
    assign a_ext   = CW'(signed'(a_op));
    assign acc_ext = CW'(signed'(acc_reg));
    assign pt_room = 32'(pcount_reg) < MAX_POINTS;
    assign pt_hit  = (32'(in_reg.point_index) < 32'(pcount_reg))
                  && (32'(in_reg.point_index) < MAX_POINTS);
    assign pt_we   = (state_reg == ST_EXEC) && (in_reg.kind == K_MARK) && pt_room;
    assign div_shift = {acc_reg, x_reg[DATA_WIDTH-1]};

    // shared adder operand select
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_EXEC: begin
                add_x   = {1'b0, a_op};
                add_y   = {1'b0, b_op};
                add_sub = (in_reg.kind == K_SUB) || (in_reg.kind == K_DEC);
                if ((in_reg.kind == K_DEC) || (in_reg.kind == K_INC)) begin
                    add_y = (DATA_WIDTH + 1)'(1);
                end
            end
            ST_MUL: begin
                add_x = {1'b0, acc_reg};
                add_y = {1'b0, x_reg};
            end
            ST_ABSA: begin
                add_y   = {1'b0, x_reg};
                add_sub = 1'b1;
            end
            ST_ABSB: begin
                add_y   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            ST_DIV: begin
                add_x   = div_shift;
                add_y   = {1'b0, y_reg};
                add_sub = 1'b1;
            end
            ST_NEGQ: begin
                add_y   = {1'b0, x_reg};
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + (DATA_WIDTH + 1)'(add_sub);

    // register file and point list
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_raw_reg <= rf_mem[d_idx];
            b_raw_reg <= rf_mem[s_idx];
        end
        if (load_out && wr_en_reg) begin
            rf_mem[d_idx_reg] <= acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pt_rd_reg <= pt_mem[PAW'(s_beat.point_index)];
        end
        if (pt_we) begin
            pt_mem[PAW'(pcount_reg)] <= in_reg.current_counter;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rf_vld_reg   <= '0;
            pcount_reg   <= '0;
            zero_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (load_out && wr_en_reg) begin
                rf_vld_reg[d_idx_reg] <= 1'b1;
            end
            if (pt_we) begin
                pcount_reg <= pcount_reg + PCW'(1);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_FIN;
                    case (in_reg.kind) inside
                        K_ADD, K_SUB, K_DEC: begin
                            zero_reg <= (add_sum[DATA_WIDTH-1:0] == '0);
                        end
                        K_MUL: begin
                            state_reg <= ST_MUL;
                        end
                        K_DIV: begin
                            if (b_op != '0) begin
                                state_reg <= ST_ABSA;
                            end
                        end
                        K_CMPLE: begin
                            zero_reg <= (a_ext <= imm_ext);
                        end
                        default: begin
                            zero_reg <= zero_reg;
                        end
                    endcase
                end
                ST_MUL: begin
                    if (cnt_reg == CNTW'(1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_ABSA: begin
                    state_reg <= ST_ABSB;
                end
                ST_ABSB: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == CNTW'(1)) begin
                        state_reg <= ST_NEGQ;
                    end
                end
                ST_NEGQ: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg    <= s_beat;
            d_idx_reg <= d_idx;
            a_vld_reg <= rf_vld_reg[d_idx];
            b_vld_reg <= rf_vld_reg[s_idx];
        end
        unique case (state_reg)
            ST_EXEC: begin
                acc_reg   <= a_op;
                wr_en_reg <= 1'b0;
                err_reg   <= ERR_OK;
                next_reg  <= in_reg.current_counter;
                taken_reg <= 1'b0;
                x_reg     <= a_op;
                y_reg     <= b_op;
                cnt_reg   <= CNTW'(DATA_WIDTH);
                neg_q_reg <= a_op[DATA_WIDTH-1] ^ b_op[DATA_WIDTH-1];
                case (in_reg.kind) inside
                    K_ADD, K_SUB, K_DEC, K_INC: begin
                        acc_reg   <= add_sum[DATA_WIDTH-1:0];
                        wr_en_reg <= 1'b1;
                    end
                    K_MUL: begin
                        acc_reg   <= '0;
                        wr_en_reg <= 1'b1;
                    end
                    K_DIV: begin
                        if (b_op == '0) begin
                            err_reg <= ERR_DIVZ;
                        end else begin
                            acc_reg   <= '0;
                            wr_en_reg <= 1'b1;
                        end
                    end
                    K_MOVIMM: begin
                        acc_reg   <= imm_ext[DATA_WIDTH-1:0];
                        wr_en_reg <= 1'b1;
                    end
                    K_COPY: begin
                        acc_reg   <= b_op;
                        wr_en_reg <= 1'b1;
                    end
                    K_MARK: begin
                        if (!pt_room) begin
                            err_reg <= ERR_POINT;
                        end
                    end
                    K_JUMP: begin
                        next_reg  <= in_reg.jump_target;
                        taken_reg <= 1'b1;
                    end
                    K_JZ: begin
                        if (zero_reg) begin
                            next_reg  <= in_reg.jump_target;
                            taken_reg <= 1'b1;
                        end
                    end
                    K_JPOINT: begin
                        if (pt_hit) begin
                            next_reg  <= pt_rd_reg;
                            taken_reg <= 1'b1;
                        end else begin
                            err_reg <= ERR_POINT;
                        end
                    end
                    default: begin
                        wr_en_reg <= 1'b0;
                    end
                endcase
            end
            ST_MUL: begin
                if (y_reg[0]) begin
                    acc_reg <= add_sum[DATA_WIDTH-1:0];
                end
                x_reg   <= x_reg << 1;
                y_reg   <= y_reg >> 1;
                cnt_reg <= cnt_reg - CNTW'(1);
            end
            ST_ABSA: begin
                if (x_reg[DATA_WIDTH-1]) begin
                    x_reg <= add_sum[DATA_WIDTH-1:0];
                end
            end
            ST_ABSB: begin
                if (y_reg[DATA_WIDTH-1]) begin
                    y_reg <= add_sum[DATA_WIDTH-1:0];
                end
            end
            ST_DIV: begin
                // restoring step, quotient bits shift into x
                if (!add_sum[DATA_WIDTH]) begin
                    acc_reg <= add_sum[DATA_WIDTH-1:0];
                end else begin
                    acc_reg <= div_shift[DATA_WIDTH-1:0];
                end
                x_reg   <= {x_reg[DATA_WIDTH-2:0], ~add_sum[DATA_WIDTH]};
                cnt_reg <= cnt_reg - CNTW'(1);
            end
            ST_NEGQ: begin
                acc_reg <= neg_q_reg ? add_sum[DATA_WIDTH-1:0] : x_reg;
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
        if (load_out) begin
            out_reg.pad          <= '0;
            out_reg.error        <= err_reg;
            out_reg.zero_flag    <= zero_reg;
            out_reg.reg_value    <= acc_ext[31:0];
            out_reg.branch_taken <= taken_reg;
            out_reg.next_counter <= next_reg;
        end
    end

    `RME_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE,
        "accepted beat did not start the sequencer")
    `RME_ASSERT_IMP(a_no_overwrite, load_out, !m_tvalid_reg || m_tready,
        "result loaded over a beat not yet taken")
    `RME_ASSERT_IMP(a_count_live, (state_reg == ST_MUL) || (state_reg == ST_DIV),
        cnt_reg != '0, "bit counter ran out inside a serial loop")
    `RME_ASSERT_IMP(a_points_bound, 1'b1, 32'(pcount_reg) <= MAX_POINTS,
        "point count beyond capacity")

endmodule

>>> verif/register_machine_execute_checker.sv
// ----------------------------------------------------------------------------
// register machine execute checker
// watches both beat channels, runs its own copy of the machine state to work
// out each expected result beat, and compares result beats field by field
// ----------------------------------------------------------------------------
module register_machine_execute_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [rme_pkg::IN_W-1:0]   s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [rme_pkg::OUT_W-1:0]  m_tdata,
    output int                         mismatches,
    output int                         pending,
    output int                         n_results,
    output int                         n_taken,
    output int                         n_divz,
    output int                         n_point_err
);
    import rme_pkg::*;

    localparam int NREGS   = 4;
    localparam int NPOINTS = 16;

    logic [31:0] gpr [NREGS];
    logic        zf;
    logic [15:0] saved_pts [NPOINTS];
    int          n_saved;

    out_beat_t   results_due[$];
    out_beat_t   got;
    out_beat_t   want;

    function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic out_beat_t execute_instr(in_beat_t ib);
        out_beat_t   r;
        logic [1:0]  d;
        logic [1:0]  s;
        d = ib.dest_reg;
        s = ib.src_reg;
        r = '0;
        r.next_counter = ib.current_counter;
        r.error        = ERR_OK;
        case (ib.kind)
            K_ADD: begin
                gpr[d] = gpr[d] + gpr[s];
                zf = (gpr[d] == 32'd0);
            end
            K_SUB: begin
                gpr[d] = gpr[d] - gpr[s];
                zf = (gpr[d] == 32'd0);
            end
            K_MUL: gpr[d] = gpr[d] * gpr[s];
            K_DIV: begin
                if (gpr[s] == 32'd0) begin
                    r.error = ERR_DIVZ;
                end else begin
                    gpr[d] = signed_quotient(gpr[d], gpr[s]);
                end
            end
            K_DEC: begin
                gpr[d] = gpr[d] - 32'd1;
                zf = (gpr[d] == 32'd0);
            end
            K_INC:    gpr[d] = gpr[d] + 32'd1;
            K_MOVIMM: gpr[d] = ib.immediate;
            K_COPY:   gpr[d] = gpr[s];
            K_MARK: begin
                if (n_saved < NPOINTS) begin
                    saved_pts[n_saved] = ib.current_counter;
                    n_saved++;
                end else begin
                    r.error = ERR_POINT;
                end
            end
            K_JUMP: begin
                r.next_counter = ib.jump_target;
                r.branch_taken = 1'b1;
            end
            K_JZ: begin
                if (zf) begin
                    r.next_counter = ib.jump_target;
                    r.branch_taken = 1'b1;
                end
            end
            K_JPOINT: begin
                if (int'(ib.point_index) < n_saved) begin
                    r.next_counter = saved_pts[ib.point_index];
                    r.branch_taken = 1'b1;
                end else begin
                    r.error = ERR_POINT;
                end
            end
            K_CMPLE: zf = ($signed(gpr[d]) <= $signed(ib.immediate));
            default: ;
        endcase
        r.reg_value = gpr[d];
        r.zero_flag = zf;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (gpr[i]) gpr[i] = '0;
            foreach (saved_pts[i]) saved_pts[i] = '0;
            zf          = 1'b0;
            n_saved     = 0;
            mismatches  = 0;
            n_results   = 0;
            n_taken     = 0;
            n_divz      = 0;
            n_point_err = 0;
            results_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (results_due.size() == 0) begin
                    $error("result beat with no instruction outstanding");
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    n_results++;
                    if (want.branch_taken) n_taken++;
                    if (want.error == ERR_DIVZ) n_divz++;
                    if (want.error == ERR_POINT) n_point_err++;
                    if (got.next_counter !== want.next_counter) begin
                        $error("next_counter: expected %0h, got %0h",
                               want.next_counter, got.next_counter);
                        mismatches++;
                    end
                    if (got.branch_taken !== want.branch_taken) begin
                        $error("branch_taken: expected %0b, got %0b",
                               want.branch_taken, got.branch_taken);
                        mismatches++;
                    end
                    if (got.reg_value !== want.reg_value) begin
                        $error("reg_value: expected %0h, got %0h",
                               want.reg_value, got.reg_value);
                        mismatches++;
                    end
                    if (got.zero_flag !== want.zero_flag) begin
                        $error("zero_flag: expected %0b, got %0b",
                               want.zero_flag, got.zero_flag);
                        mismatches++;
                    end
                    if (got.error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, got.error);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                results_due = {results_due, execute_instr(in_beat_t'(s_tdata))};
            end
        end
        pending = results_due.size();
    end

endmodule

>>> verif/register_machine_execute_tb.sv
// ----------------------------------------------------------------------------
// register machine execute testbench
// drives a directed instruction set then random instruction streams with
// random gaps and back-pressure, and lets the checker judge every result beat
// ----------------------------------------------------------------------------
module register_machine_execute_tb;
    import rme_pkg::*;

    localparam logic [3:0] K_SPARE_LO = 4'd14;
    localparam logic [3:0] K_SPARE_HI = 4'd15;

    localparam int RANDOM_INSTRS = 1700;
    localparam int HOLD_AT       = 500;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_AT      = 1000;
    localparam int TAIL_CYCLES   = 50;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    int mismatches;
    int pending;
    int n_results;
    int n_taken;
    int n_divz;
    int n_point_err;
    int instrs_sent;
    in_beat_t directed[$];

    register_machine_execute u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    register_machine_execute_checker u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .pending     (pending),
        .n_results   (n_results),
        .n_taken     (n_taken),
        .n_divz      (n_divz),
        .n_point_err (n_point_err)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic in_beat_t instr(logic [3:0] k, int d, int s,
                                       logic [31:0] imm, logic [15:0] tgt,
                                       int pidx, logic [15:0] cur);
        in_beat_t b;
        b                 = '0;
        b.kind            = k;
        b.dest_reg        = 2'(d);
        b.src_reg         = 2'(s);
        b.immediate       = imm;
        b.jump_target     = tgt;
        b.point_index     = 4'(pidx);
        b.current_counter = cur;
        return b;
    endfunction

    task automatic add_directed(in_beat_t b);
        directed = {directed, b};
    endtask

    function automatic logic [31:0] pick_imm();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 8) - 4;
        if (r < 55) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    // biased toward kinds whose outcome hinges on state built up earlier
    function automatic in_beat_t rand_instr();
        logic [3:0] k;
        k = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) >= 6) begin
            case ($urandom_range(0, 4))
                0:       k = K_MOVIMM;
                1:       k = K_DIV;
                2:       k = K_JZ;
                3:       k = K_CMPLE;
                default: k = K_JPOINT;
            endcase
        end
        return instr(k, $urandom_range(0, 3), $urandom_range(0, 3), pick_imm(),
                     16'($urandom_range(0, 65535)), $urandom_range(0, 15),
                     16'($urandom_range(0, 65535)));
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // entered and left at a falling edge
    task automatic send_instr(in_beat_t b, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        instrs_sent++;
        @(negedge aclk);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        instrs_sent = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_directed(instr(K_MOVIMM, 0, 0, 32'h7fff_ffff, 16'h0000, 0, 16'h0001));
        add_directed(instr(K_MOVIMM, 1, 0, 32'h8000_0000, 16'hffff, 0, 16'h0002));
        add_directed(instr(K_MOVIMM, 2, 0, 32'hffff_ffff, 16'h0000, 0, 16'h0003));
        add_directed(instr(K_INC,    0, 0, 32'h0,         16'h0000, 0, 16'h0004));
        add_directed(instr(K_DIV,    1, 2, 32'h0,         16'h0000, 0, 16'h0005));
        add_directed(instr(K_DIV,    0, 3, 32'h0,         16'h0000, 0, 16'h0006));
        add_directed(instr(K_ADD,    3, 2, 32'h0,         16'h0000, 0, 16'h0007));
        add_directed(instr(K_SUB,    2, 2, 32'h0,         16'h0000, 0, 16'h0008));
        add_directed(instr(K_JZ,     2, 0, 32'h0,         16'hffff, 0, 16'h0000));
        add_directed(instr(K_MARK,   0, 0, 32'h0,         16'h0000, 0, 16'hffff));
        add_directed(instr(K_JPOINT, 0, 0, 32'h0,         16'h0000, 0, 16'h0010));
        add_directed(instr(K_JPOINT, 0, 0, 32'h0,         16'h0000, 15, 16'h0011));
        add_directed(instr(K_MUL,    1, 1, 32'h0,         16'h0000, 0, 16'h0012));
        add_directed(instr(K_MOVIMM, 2, 0, 32'h0000_0001, 16'h0000, 0, 16'h0013));
        add_directed(instr(K_DEC,    2, 0, 32'h0,         16'h0000, 0, 16'h0014));
        add_directed(instr(K_DEC,    2, 0, 32'h0,         16'h0000, 0, 16'h0015));
        add_directed(instr(K_JZ,     0, 0, 32'h0,         16'h1234, 0, 16'h0016));
        add_directed(instr(K_COPY,   3, 0, 32'h0,         16'h0000, 0, 16'h0017));
        add_directed(instr(K_CMPLE,  0, 0, 32'h8000_0000, 16'h0000, 0, 16'h0018));
        add_directed(instr(K_CMPLE,  2, 0, 32'h8000_0000, 16'h0000, 0, 16'h0019));
        add_directed(instr(K_CMPLE,  3, 0, 32'h7fff_ffff, 16'h0000, 0, 16'h001a));
        add_directed(instr(K_JUMP,   0, 0, 32'h0,         16'hffff, 0, 16'hffff));
        add_directed(instr(K_READ,   3, 0, 32'h0,         16'h0000, 0, 16'h0000));
        add_directed(instr(K_SPARE_LO, 1, 2, 32'hffff_ffff, 16'hffff, 15, 16'h00ff));
        add_directed(instr(K_SPARE_HI, 2, 3, 32'h0,       16'h0000, 0, 16'hff00));
        foreach (directed[i]) send_instr(directed[i], pick_gap());

        for (int i = 0; i < RANDOM_INSTRS; i++) begin
            // sender sits idle until every outstanding result is back
            if (i == DRAIN_AT) begin
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
            // a stretch of back-to-back beats every so often
            send_instr(rand_instr(), (i % 250 < 40) ? 0 : pick_gap());
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("sent %0d instruction beats, checked %0d result beats, %0d jumps taken",
                 instrs_sent, n_results, n_taken);
        $display("divide-by-zero results: %0d, point list errors: %0d",
                 n_divz, n_point_err);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS register_machine_execute");
        end else begin
            $display("FAIL register_machine_execute");
        end
        $finish;
    end

    initial begin
        bit          hold_done;
        int unsigned hi_len;
        int unsigned lo_len;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            // one long hold-off so the block fills up and stalls its input
            if (!hold_done && instrs_sent >= HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            hi_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (hi_len) @(negedge aclk);
            lo_len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
            m_tready <= 1'b0;
            repeat (lo_len) @(negedge aclk);
        end
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("FAIL register_machine_execute");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/rme_pkg.sv
hdl/register_machine_execute.sv
verif/register_machine_execute_checker.sv
verif/register_machine_execute_tb.sv
